// ===== rtl/tct_pkg.sv =====
// Package for the touch contact tracker: field widths, operation and status codes,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
package tct_pkg;

   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int FINGER_W   = 16;
   localparam int COORD_W    = 16;
   localparam int POS_W      = 3 * COORD_W;
   localparam int MOTION_W   = 17;
   localparam int MOTIONS_W  = 3 * MOTION_W;
   localparam int BUTTON_W   = 6;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_USED_W = BUTTON_W + POS_W + MOTIONS_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_BEGIN  = 2'd0,
      CMD_UPDATE = 2'd1,
      CMD_FINISH = 2'd2,
      CMD_NONE   = 2'd3
   } tct_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_UNKNOWN   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NO_BUTTON = 2'd3
   } tct_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_READ,
      S_EXEC
   } tct_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the incoming word
      logic lookup;  // register the table search
      logic read;    // read the entry and free stack memories
      logic commit;  // update state and present the result
   } tct_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;  // result register can take a new word this cycle
   } tct_stat_type;

endpackage

// ===== rtl/tct_ctrl.sv =====
// Controller for the touch contact tracker: a four-state sequencer that owns the
// input handshake and steps the datapath. Depends on tct_pkg.
module tct_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  tct_pkg::tct_stat_type stat,
   output tct_pkg::tct_cmd_type  cmd
);
   import tct_pkg::*;

   tct_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_LOOKUP;
         end
         S_LOOKUP: state_in = S_READ;
         S_READ:   state_in = S_EXEC;
         S_EXEC: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_LOOKUP: cmd.lookup = 1'b1;
         S_READ:   cmd.read   = 1'b1;
         S_EXEC:   cmd.commit = stat.out_free;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/tct_datapath.sv =====
// Datapath for the touch contact tracker: contact table, free button stack, top
// counter, motion arithmetic and the result register. Depends on tct_pkg.
module tct_datapath #(
   parameter int MAX_CONTACTS = 16,
   parameter int MAX_BUTTONS  = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tct_pkg::tct_cmd_type            cmd,
   output tct_pkg::tct_stat_type           stat,
   input  logic [tct_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [tct_pkg::CMD_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tct_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [tct_pkg::STATUS_W-1:0]    rsp_tuser
);
   import tct_pkg::*;

   localparam int CIDX_W = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
   localparam int SIDX_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
   localparam logic [BUTTON_W-1:0] TOP_LIMIT = BUTTON_W'(MAX_BUTTONS);

   // Captured word.
   tct_op_type          op_ff;
   logic [FINGER_W-1:0] finger_ff;
   logic [POS_W-1:0]    pos_ff;

   // Contact table: valid bits and finger ids in flip-flops for the parallel search,
   // button and position in memories.
   logic [MAX_CONTACTS-1:0] valid_ff, valid_in;
   logic [FINGER_W-1:0]     fid_ff [MAX_CONTACTS];
   logic [BUTTON_W-1:0]     btn_mem_ff [MAX_CONTACTS];
   logic [POS_W-1:0]        pos_mem_ff [MAX_CONTACTS];
   logic [BUTTON_W-1:0]     stack_mem_ff [MAX_BUTTONS];

   logic [BUTTON_W-1:0] top_ff, top_in;
   logic [BUTTON_W-1:0] count_ff, count_in;
   logic [BUTTON_W-1:0] count_m1;

   // Search results and memory read data.
   logic              found_ff, found_in;
   logic              has_free_ff, has_free_in;
   logic [CIDX_W-1:0] match_idx_ff, match_idx_in;
   logic [CIDX_W-1:0] free_idx_ff, free_idx_in;
   logic [BUTTON_W-1:0] btn_rd_ff;
   logic [POS_W-1:0]    pos_rd_ff;
   logic [BUTTON_W-1:0] stack_rd_ff;

   // Result register.
   logic                 rsp_valid_ff;
   tct_status_type       rsp_status_ff, res_status;
   logic [BUTTON_W-1:0]  rsp_button_ff, res_button;
   logic [POS_W-1:0]     rsp_pos_ff, res_pos;
   logic [MOTIONS_W-1:0] rsp_motion_ff, res_motion;
   logic                 res_emit;

   // Write controls for the commit step.
   logic              id_we, pos_we, stk_we;
   logic [CIDX_W-1:0] ent_idx;
   logic [BUTTON_W-1:0] new_btn;

   assign count_m1 = count_ff - BUTTON_W'(1);

   // Capture of the incoming word.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= tct_op_type'(req_tuser);
         finger_ff <= req_tdata[FINGER_W-1:0];
         pos_ff    <= req_tdata[FINGER_W +: POS_W];
      end
   end

   // Parallel search: lowest valid entry with a matching finger, lowest free entry.
   always_comb begin
      found_in     = 1'b0;
      has_free_in  = 1'b0;
      match_idx_in = '0;
      free_idx_in  = '0;
      for (int i = MAX_CONTACTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && (fid_ff[i] == finger_ff)) begin
            found_in     = 1'b1;
            match_idx_in = CIDX_W'(i);
         end
         if (!valid_ff[i]) begin
            has_free_in = 1'b1;
            free_idx_in = CIDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         found_ff     <= found_in;
         has_free_ff  <= has_free_in;
         match_idx_ff <= match_idx_in;
         free_idx_ff  <= free_idx_in;
      end
      if (cmd.read) begin
         btn_rd_ff   <= btn_mem_ff[match_idx_ff];
         pos_rd_ff   <= pos_mem_ff[match_idx_ff];
         stack_rd_ff <= stack_mem_ff[count_m1[SIDX_W-1:0]];
      end
   end

   // Commit step: works out the new state and the result word.
   always_comb begin
      logic ok;
      logic [MOTION_W-1:0] d;
      valid_in   = valid_ff;
      top_in     = top_ff;
      count_in   = count_ff;
      id_we      = 1'b0;
      pos_we     = 1'b0;
      stk_we     = 1'b0;
      ent_idx    = match_idx_ff;
      new_btn    = stack_rd_ff;
      res_emit   = 1'b0;
      res_status = ST_OK;
      res_button = '0;
      res_pos    = '0;
      res_motion = '0;
      ok         = 1'b0;
      d          = '0;
      case (op_ff) inside
         CMD_BEGIN: begin
            res_emit = 1'b1;
            if (!found_ff && !has_free_ff) begin
               res_status = ST_FULL;
            end else begin
               ent_idx = found_ff ? match_idx_ff : free_idx_ff;
               if (count_ff != '0) begin
                  new_btn  = stack_rd_ff;
                  count_in = count_m1;
                  ok       = 1'b1;
               end else if (top_ff < TOP_LIMIT) begin
                  top_in  = top_ff + BUTTON_W'(1);
                  new_btn = top_in;
                  ok      = 1'b1;
               end else begin
                  res_status = ST_NO_BUTTON;
               end
               if (ok) begin
                  id_we             = 1'b1;
                  pos_we            = 1'b1;
                  valid_in[ent_idx] = 1'b1;
                  res_button        = new_btn;
                  res_pos           = pos_ff;
               end
            end
         end
         CMD_UPDATE, CMD_FINISH: begin
            res_emit = 1'b1;
            if (!found_ff) begin
               res_status = ST_UNKNOWN;
            end else begin
               pos_we     = 1'b1;
               res_button = btn_rd_ff;
               res_pos    = pos_ff;
               for (int k = 0; k < 3; k++) begin
                  d = {pos_rd_ff[k*COORD_W + COORD_W - 1], pos_rd_ff[k*COORD_W +: COORD_W]}
                    - {pos_ff[k*COORD_W + COORD_W - 1], pos_ff[k*COORD_W +: COORD_W]};
                  res_motion[k*MOTION_W +: MOTION_W] = d;
               end
               if (op_ff == CMD_FINISH) begin
                  valid_in[match_idx_ff] = 1'b0;
                  // The highest button lowers the top counter; others go on a non-full stack.
                  if (btn_rd_ff == top_ff) begin
                     if (top_ff != '0) top_in = top_ff - BUTTON_W'(1);
                  end else if (count_ff < TOP_LIMIT) begin
                     stk_we   = 1'b1;
                     count_in = count_ff + BUTTON_W'(1);
                  end
               end
            end
         end
         default: begin
            res_emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         top_ff   <= '0;
         count_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff <= valid_in;
         top_ff   <= top_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && id_we) begin
         fid_ff[ent_idx]     <= finger_ff;
         btn_mem_ff[ent_idx] <= new_btn;
      end
      if (cmd.commit && pos_we) begin
         pos_mem_ff[ent_idx] <= pos_ff;
      end
      if (cmd.commit && stk_we) begin
         stack_mem_ff[count_ff[SIDX_W-1:0]] <= btn_rd_ff;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit && res_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && res_emit) begin
         rsp_status_ff <= res_status;
         rsp_button_ff <= res_button;
         rsp_pos_ff    <= res_pos;
         rsp_motion_ff <= res_motion;
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tuser     = rsp_status_ff;
   assign rsp_tdata     = {{RSP_PAD_W{1'b0}}, rsp_motion_ff, rsp_pos_ff, rsp_button_ff};

endmodule

// ===== rtl/touch_contact_tracker_unit.sv =====
// Top level of the touch contact tracker: joins the controller and the datapath.
// Depends on tct_pkg, tct_ctrl and tct_datapath.
//
//  channel  direction  word contents
//  req_     in         tuser: command; tdata: finger_id, pos_x, pos_y, pos_z
//  rsp_     out        tuser: status; tdata: button, out_x/y/z, motion_x/y/z
//
// Each word passes through four steps from acceptance to a result in the output register:
// capture, the parallel search of the contact table, the registered reads of the button,
// position and free stack memories, and commit. A new word is accepted in the cycle
// after commit, so the block takes no new word until the last one is committed. The
// commit step waits while the output register still holds an untaken result. Reset
// clears the valid bits, the top counter and the free count at once; no clearing
// pass is needed.
// A word with the unused command code gives no result and changes nothing.
module touch_contact_tracker_unit #(
   parameter int MAX_CONTACTS = 16,
   parameter int MAX_BUTTONS  = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [15:0] finger_id, [31:16] pos_x, [47:32] pos_y, [63:48] pos_z
   input  logic [tct_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [tct_pkg::CMD_W-1:0]      req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [5:0] button, [21:6] out_x, [37:22] out_y, [53:38] out_z,
   // [70:54] motion_x, [87:71] motion_y, [104:88] motion_z, rest zero
   output logic [tct_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [tct_pkg::STATUS_W-1:0]   rsp_tuser
);
   import tct_pkg::*;

   tct_cmd_type  cmd;
   tct_stat_type stat;

   // The controller sequences each word through search, read and commit.
   tct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath holds the contact table, the button allocator and the result register.
   tct_datapath #(
      .MAX_CONTACTS (MAX_CONTACTS),
      .MAX_BUTTONS  (MAX_BUTTONS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef NO_ASSERTIONS
   // Once a word is taken, the block is busy until that word has been worked through.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted again in the cycle after an accept");

   // A failed result has no button or position; this checks the button.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_OK)) |-> (rsp_tdata[BUTTON_W-1:0] == '0))
      else $error("error result carries a non-zero button");

   // A successful operation always names a button in range.
   a_ok_button: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == ST_OK)) |->
         ((rsp_tdata[BUTTON_W-1:0] != '0) &&
          (rsp_tdata[BUTTON_W-1:0] <= BUTTON_W'(MAX_BUTTONS))))
      else $error("successful result with a button out of range");
`endif

endmodule
